// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the run-length encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge of clk_i outside reset.
`define TRLE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("trle assertion failed");

// Expression must never be true at a rising edge of clk_i outside reset.
`define TRLE_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("trle forbidden condition seen");

`endif

// ----- rtl/core/trle_pkg.sv -----
// Shared types and constants of the threshold run-length encoder.
package trle_pkg;

  // Field widths of the ports.
  localparam int unsigned PixelW   = 8;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned StartW   = 12;
  localparam int unsigned RowW     = 12;
  localparam int unsigned LenW     = 13;

  // Register reset values.
  localparam logic [PixelW-1:0] ThresholdRst = 8'd128;
  localparam logic [DimW-1:0]   WidthRst     = 13'd640;
  localparam logic [DimW-1:0]   HeightRst    = 13'd480;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_DILATE    = 2'd3
  } cfg_reg_e;

  // Effective configuration, dimensions already clamped to their legal range.
  typedef struct packed {
    logic [PixelW-1:0] threshold;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic              dilate;
  } cfg_t;

endpackage

// ----- rtl/core/threshold_rle_with_dilation.sv -----
// Top level of the threshold run-length encoder with horizontal dilation.
//
// Grey pixels enter in raster order, one per transfer, and leave as one
// result per horizontal foreground run (start column, row, length). The
// block takes one pixel per clock at full rate: a pixel sits in an input
// register, the run state (column, row, open run, last two mask bits) is
// updated from it, and a closed run lands in an output register. The state
// update is what sets the rate; the pipeline stalls only while a result
// waits on run_ready_i. With dilation on, a run is reported one pixel
// later than without, and a run ending at the row end is flushed by the
// last pixel of the row. Configuration writes take effect for the next
// pixel and are meant for idle periods; cfg_ready_o is always high.
`include "assert_macros.svh"

module threshold_rle_with_dilation import trle_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel input
  input  logic                pixel_valid_i,
  output logic                pixel_ready_o,
  input  logic [PixelW-1:0]   pixel_i,
  // Run output
  output logic                run_valid_o,
  input  logic                run_ready_i,
  output logic [StartW-1:0]   run_start_x_o,
  output logic [RowW-1:0]     run_row_o,
  output logic [LenW-1:0]     run_length_o,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Column, column end and row counter widths.
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned LW = (EW > DimW) ? EW : DimW;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = ((RW + 1) > DimW) ? (RW + 1) : DimW;

  cfg_t cfg;

  trle_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // Pipeline control.
  logic              pix_vld_q;
  logic [PixelW-1:0] pix_q;
  logic              advance;
  logic              step;

  assign advance       = !run_valid_o || run_ready_i;
  assign step          = pix_vld_q && advance;
  assign pixel_ready_o = !pix_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
    end else if (pixel_ready_o) begin
      pix_vld_q <= pixel_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_valid_i && pixel_ready_o) begin
      pix_q <= pixel_i;
    end
  end

  // Run state.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [1:0]    rf_q, rf_d;
  logic          open_q, open_d;
  logic [CW-1:0] start_q, start_d;

  // Step logic for the pixel in the input register.
  logic          fg;
  logic          last;
  logic [EW-1:0] c1;
  logic          f1, f2, dmask, mask;
  logic          hit;
  logic [EW-1:0] end_v;
  logic [CW-1:0] pos;
  logic [CW-1:0] res_start;
  logic [EW-1:0] res_len;

  assign fg   = (pix_q >= cfg.threshold);
  assign last = ((LW'(col_q) + LW'(1)) >= LW'(cfg.width));
  assign c1   = EW'(col_q) + EW'(1);

  always_comb begin
    open_d    = open_q;
    start_d   = start_q;
    hit       = 1'b0;
    res_start = start_q;
    res_len   = '0;
    end_v     = EW'(col_q);
    f1        = (col_q != '0) && rf_q[0];
    f2        = (col_q > CW'(1)) && rf_q[1];
    mask      = f2 || f1 || fg;
    dmask     = f1 || fg;
    pos       = col_q - CW'(1);

    if (!cfg.dilate) begin
      // Plain mask: open on foreground, close on background.
      if (fg && !open_d) begin
        open_d  = 1'b1;
        start_d = col_q;
      end else if (!fg && open_d) begin
        if (EW'(col_q) > EW'(start_d)) begin
          hit       = 1'b1;
          res_start = start_d;
          res_len   = EW'(col_q) - EW'(start_d);
        end
        open_d = 1'b0;
      end
      // Row end closes a run still open after this pixel.
      if (last && open_d && !hit) begin
        if (c1 > EW'(start_d)) begin
          hit       = 1'b1;
          res_start = start_d;
          res_len   = c1 - EW'(start_d);
        end
        open_d = 1'b0;
      end
    end else begin
      // Dilated mask of the previous column is now complete.
      if (col_q != '0) begin
        if (mask && !open_d) begin
          open_d  = 1'b1;
          start_d = pos;
        end else if (!mask && open_d) begin
          if (EW'(pos) > EW'(start_d)) begin
            hit       = 1'b1;
            res_start = start_d;
            res_len   = EW'(pos) - EW'(start_d);
          end
          open_d = 1'b0;
        end
      end
      // Row end flushes the last column, which sees no right neighbor.
      if (last && !hit) begin
        if (dmask && !open_d) begin
          open_d  = 1'b1;
          start_d = col_q;
        end
        if (open_d) begin
          end_v = dmask ? c1 : EW'(col_q);
          if (end_v > EW'(start_d)) begin
            hit       = 1'b1;
            res_start = start_d;
            res_len   = end_v - EW'(start_d);
          end
          open_d = 1'b0;
        end
      end
    end

    // Counters and mask history.
    rf_d = {rf_q[0], fg};
    if (last) begin
      col_d  = '0;
      rf_d   = '0;
      open_d = 1'b0;
      if ((HW'(row_q) + HW'(1)) >= HW'(cfg.height)) begin
        row_d = '0;
      end else begin
        row_d = row_q + RW'(1);
      end
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      rf_q    <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
    end else if (step) begin
      col_q   <= col_d;
      row_q   <= row_d;
      rf_q    <= rf_d;
      open_q  <= open_d;
      start_q <= start_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_o <= 1'b0;
    end else if (advance) begin
      run_valid_o <= step && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && hit) begin
      run_start_x_o <= StartW'(res_start);
      run_row_o     <= RowW'(row_q);
      run_length_o  <= LenW'(res_len);
    end
  end

  // Checks on the run state and the pipeline.
  `TRLE_ASSERT(a_len_nonzero, run_valid_o |-> (run_length_o != '0))
  `TRLE_ASSERT(a_open_before_col, open_q |-> (start_q < col_q))
  `TRLE_ASSERT(a_row_end_clears, (step && last) |=> (!open_q && rf_q == '0 && col_q == '0))
  `TRLE_ASSERT_NEVER(a_stall_drop, $past(pix_vld_q && !advance) && !pix_vld_q)

endmodule

// ----- rtl/core/trle_cfg.sv -----
// Configuration registers with write decode and dimension clamping.
module trle_cfg import trle_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  // Largest legal dimension that a 13-bit register can express.
  localparam int unsigned DimMax = (1 << DimW) - 1;
  localparam logic [DimW-1:0] WidthLim =
    (MAX_WIDTH > DimMax) ? DimW'(DimMax) : DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0] HeightLim =
    (MAX_HEIGHT > DimMax) ? DimW'(DimMax) : DimW'(MAX_HEIGHT);

  logic [PixelW-1:0] threshold_q;
  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic              dilate_q;

  // Register write on each configuration transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
      dilate_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_THRESHOLD: threshold_q <= cfg_data_i[PixelW-1:0];
        REG_WIDTH:     width_q     <= cfg_data_i[DimW-1:0];
        REG_HEIGHT:    height_q    <= cfg_data_i[DimW-1:0];
        REG_DILATE:    dilate_q    <= cfg_data_i[0];
      endcase
    end
  end

  // A zero dimension acts as one, oversize values act as the maximum.
  always_comb begin
    cfg_o.threshold = threshold_q;
    cfg_o.dilate    = dilate_q;
    if (width_q == '0) begin
      cfg_o.width = DimW'(1);
    end else if (width_q > WidthLim) begin
      cfg_o.width = WidthLim;
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = DimW'(1);
    end else if (height_q > HeightLim) begin
      cfg_o.height = HeightLim;
    end else begin
      cfg_o.height = height_q;
    end
  end

endmodule
